// ===== hdl/spn16_pkg.sv =====
// ----------------------------------------------------------------------------
// spn16_pkg
// Shared constants, types and round functions for the 16-bit SPN cipher.
// ----------------------------------------------------------------------------
package spn16_pkg;

    localparam int BLOCK_W  = 16;
    localparam int KEY_W    = 32;
    localparam int NIBBLE_W = 4;
    localparam int N_ROUNDS = 5;
    localparam int RKEY_STEP = 4;

    typedef logic [BLOCK_W-1:0]  t_block;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [NIBBLE_W-1:0] t_nibble;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_opcode;

    function automatic t_nibble sbox_fwd(input t_nibble x);
        t_nibble y;
        case (x)
            4'h0: y = 4'hE;
            4'h1: y = 4'h4;
            4'h2: y = 4'hD;
            4'h3: y = 4'h1;
            4'h4: y = 4'h2;
            4'h5: y = 4'hF;
            4'h6: y = 4'hB;
            4'h7: y = 4'h8;
            4'h8: y = 4'h3;
            4'h9: y = 4'hA;
            4'hA: y = 4'h6;
            4'hB: y = 4'hC;
            4'hC: y = 4'h5;
            4'hD: y = 4'h9;
            4'hE: y = 4'h0;
            default: y = 4'h7;
        endcase
        return y;
    endfunction

    function automatic t_nibble sbox_inv(input t_nibble x);
        t_nibble y;
        case (x)
            4'h0: y = 4'hE;
            4'h1: y = 4'h3;
            4'h2: y = 4'h4;
            4'h3: y = 4'h8;
            4'h4: y = 4'h1;
            4'h5: y = 4'hC;
            4'h6: y = 4'hA;
            4'h7: y = 4'hF;
            4'h8: y = 4'h7;
            4'h9: y = 4'hD;
            4'hA: y = 4'h9;
            4'hB: y = 4'h6;
            4'hC: y = 4'hB;
            4'hD: y = 4'h2;
            4'hE: y = 4'h0;
            default: y = 4'h5;
        endcase
        return y;
    endfunction

    function automatic t_block sub_fwd(input t_block x);
        t_block y;
        for (int n = 0; n < BLOCK_W / NIBBLE_W; n++) begin
            y[n*NIBBLE_W +: NIBBLE_W] = sbox_fwd(x[n*NIBBLE_W +: NIBBLE_W]);
        end
        return y;
    endfunction

    function automatic t_block sub_inv(input t_block x);
        t_block y;
        for (int n = 0; n < BLOCK_W / NIBBLE_W; n++) begin
            y[n*NIBBLE_W +: NIBBLE_W] = sbox_inv(x[n*NIBBLE_W +: NIBBLE_W]);
        end
        return y;
    endfunction

    // 4x4 bit transpose: bit b goes to 4*(b mod 4) + b/4; self-inverse
    function automatic t_block transpose(input t_block x);
        t_block y;
        for (int b = 0; b < BLOCK_W; b++) begin
            y[(b % 4) * 4 + (b / 4)] = x[b];
        end
        return y;
    endfunction

    // round key r is the 16-bit window (key >> (16 - 4r))
    function automatic t_block round_key(input t_key key, input int r);
        return key[(KEY_W - 1 - RKEY_STEP * r) -: BLOCK_W];
    endfunction

endpackage

// ===== hdl/spn16_round.sv =====
// ----------------------------------------------------------------------------
// spn16_round
// One cipher round, forward or inverse, selected per item.
// ----------------------------------------------------------------------------
module spn16_round
    import spn16_pkg::*;
(
    input  t_opcode i_opcode,
    input  t_block  i_block,
    input  t_block  i_rkey_enc,
    input  t_block  i_rkey_dec,
    output t_block  o_block
);

    t_block enc_out;
    t_block dec_out;

    assign enc_out = transpose(sub_fwd(i_block ^ i_rkey_enc));
    assign dec_out = sub_inv(transpose(i_block)) ^ i_rkey_dec;

    assign o_block = (i_opcode == OP_DECRYPT) ? dec_out : enc_out;

endmodule

// ===== hdl/spn16_datapath.sv =====
// ----------------------------------------------------------------------------
// spn16_datapath
// Five chained rounds; decryption walks the round keys in reverse.
// ----------------------------------------------------------------------------
module spn16_datapath
    import spn16_pkg::*;
#(
    parameter int NUM_ROUNDS = N_ROUNDS
) (
    input  t_opcode i_opcode,
    input  t_key    i_key,
    input  t_block  i_block,
    output t_block  o_block
);

    t_block chain [NUM_ROUNDS+1];

    assign chain[0] = i_block;

    for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
        spn16_round u_round (
            .i_opcode   (i_opcode),
            .i_block    (chain[r]),
            .i_rkey_enc (round_key(i_key, r)),
            .i_rkey_dec (round_key(i_key, NUM_ROUNDS - 1 - r)),
            .o_block    (chain[r+1])
        );
    end

    assign o_block = chain[NUM_ROUNDS];

endmodule

// ===== hdl/spn16_block_cipher.sv =====
// ----------------------------------------------------------------------------
// spn16_block_cipher
// 16-bit SPN block cipher, five rounds, 32-bit key held in a register.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     i_in_valid / o_in_stall     i_opcode, i_block_in
//  result    o_out_valid / i_out_stall   o_block_out
//  config    i_cfg_valid / o_cfg_ready   i_cfg_data (cipher key)
//
//  Path: input register, five rounds of logic, result register.
//  One item per cycle sustained while the result side does not stall; the five rounds sit in a single register stage.
//  Synchronous active-low reset empties both stages and clears the key to zero.
//  A stall on the result side backs up through both stages; each stage keeps
//  its item until it can move on, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module spn16_block_cipher
    import spn16_pkg::*;
#(
    parameter int NUM_ROUNDS = N_ROUNDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic [BLOCK_W-1:0]  i_block_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [BLOCK_W-1:0]  o_block_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [KEY_W-1:0]    i_cfg_data
);

    t_key    r_key;
    logic    r_s1_valid;
    t_opcode r_s1_op;
    t_block  r_s1_block;
    logic    r_out_valid;
    t_block  r_out_block;

    t_block  n_out_block;
    logic    out_adv;
    logic    s1_adv;

    assign out_adv = !r_out_valid || !i_out_stall;
    assign s1_adv  = !r_s1_valid || out_adv;

    assign o_in_stall  = !s1_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_block_out = r_out_block;

    spn16_datapath #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_datapath (
        .i_opcode (r_s1_op),
        .i_key    (r_key),
        .i_block  (r_s1_block),
        .o_block  (n_out_block)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in_valid) begin
            r_s1_op    <= t_opcode'(i_opcode);
            r_s1_block <= i_block_in;
        end
        if (out_adv && r_s1_valid) begin
            r_out_block <= n_out_block;
        end
    end

    // stall only ever reflects a held item that cannot move on
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked item");

    // an item in stage one that moves on shows up as a result next cycle
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_adv) |=> r_out_valid)
        else $error("item lost between stages");

    // accepted item lands in stage one
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_valid)
        else $error("accepted item not captured");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ===== bench/tb_spn16_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_spn16_block_cipher
// Self-checking bench for the 16-bit SPN cipher. Blocks go in with random
// opcodes and keys under varying sender gaps and receiver stalls. Each
// ciphertext or recovered plaintext is checked in order against a predictor.
// ----------------------------------------------------------------------------

class cipher_scoreboard;

    spn16_pkg::t_key    key;
    spn16_pkg::t_block  expected_blocks[$];
    spn16_pkg::t_nibble fwd_tab[16];
    spn16_pkg::t_nibble inv_tab[16];
    int unsigned        errors;

    function new();
        key     = '0;
        errors  = 0;
        fwd_tab = '{4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
                    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7};
        inv_tab = '{4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
                    4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5};
    endfunction

    function void set_key(spn16_pkg::t_key k);
        key = k;
    endfunction

    function spn16_pkg::t_block key_window(int r);
        spn16_pkg::t_key s;
        s = key >> (16 - 4 * r);
        return s[15:0];
    endfunction

    function spn16_pkg::t_block substitute(spn16_pkg::t_block x, bit inverse);
        spn16_pkg::t_block y;
        for (int n = 0; n < 4; n++) begin
            y[n*4 +: 4] = inverse ? inv_tab[x[n*4 +: 4]] : fwd_tab[x[n*4 +: 4]];
        end
        return y;
    endfunction

    // 4x4 bit transpose, its own inverse
    function spn16_pkg::t_block swap_bits(spn16_pkg::t_block x);
        spn16_pkg::t_block y;
        for (int b = 0; b < 16; b++) begin
            y[((b & 3) << 2) | (b >> 2)] = x[b];
        end
        return y;
    endfunction

    function spn16_pkg::t_block cipher_block(spn16_pkg::t_opcode op,
                                             spn16_pkg::t_block blk);
        spn16_pkg::t_block v;
        v = blk;
        if (op == spn16_pkg::OP_ENCRYPT) begin
            for (int r = 0; r < 5; r++) begin
                v = swap_bits(substitute(v ^ key_window(r), 1'b0));
            end
        end else begin
            for (int r = 4; r >= 0; r--) begin
                v = substitute(swap_bits(v), 1'b1) ^ key_window(r);
            end
        end
        return v;
    endfunction

    function void note_block(spn16_pkg::t_opcode op, spn16_pkg::t_block blk);
        expected_blocks.push_back(cipher_block(op, blk));
    endfunction

    function void check_block(spn16_pkg::t_block actual);
        spn16_pkg::t_block want;
        if (expected_blocks.size() == 0) begin
            $error("block_out: unexpected item, expected none, actual %h", actual);
            errors++;
        end else begin
            want = expected_blocks.pop_front();
            if (actual !== want) begin
                $error("block_out mismatch: expected %h, actual %h", want, actual);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_blocks.size();
    endfunction

endclass

module tb_spn16_block_cipher;
    timeunit 1ns;
    timeprecision 1ps;
    import spn16_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int ITEMS_PER_RUN = 210;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_in_valid  = 1'b0;
    logic         i_opcode    = 1'b0;
    t_block       i_block_in  = '0;
    logic         i_out_stall = 1'b0;
    logic         i_cfg_valid = 1'b0;
    t_key         i_cfg_data  = '0;
    logic         o_in_stall;
    logic         o_out_valid;
    t_block       o_block_out;
    logic         o_cfg_ready;

    int unsigned  in_idle_pct   = 0;
    int unsigned  out_stall_pct = 0;
    int unsigned  cycle_count   = 0;
    cipher_scoreboard sb = new();

    spn16_block_cipher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_block_in  (i_block_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_block_out (o_block_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_block(o_block_out);
        end
    end

    // called and returns at a falling edge
    task automatic send_block(t_opcode op, t_block blk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_block_in <= blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_block(op, blk);
        @(negedge i_clk);
    endtask

    task automatic write_key(t_key k);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_key(k);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every expected item has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_directed();
        t_block corners[6];
        corners = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000};
        foreach (corners[i]) begin
            send_block(OP_ENCRYPT, corners[i]);
            send_block(OP_DECRYPT, corners[i]);
        end
    endtask

    initial begin
        t_key    keys[8];
        t_block  blk;
        t_opcode op;

        keys = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_0F0F, $urandom(),
                 32'h8000_0001, $urandom(), $urandom(), $urandom()};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key first, then all ones
        send_directed();
        drain();
        write_key(32'hFFFF_FFFF);
        send_directed();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 46; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 46; end
                default: begin in_idle_pct = 20; out_stall_pct = 20; end
            endcase
            drain();
            write_key(keys[p]);
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                blk = ($urandom_range(7) == 0) ? {16{$urandom_range(1) == 1}}
                                               : t_block'($urandom());
                op  = t_opcode'($urandom_range(1));
                send_block(op, blk);
                // now and then decrypt what was just encrypted
                if (op == OP_ENCRYPT && $urandom_range(3) == 0) begin
                    send_block(OP_DECRYPT, sb.cipher_block(OP_ENCRYPT, blk));
                end
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
